// ===== sv/bsp_pkg.sv =====
`timescale 1ns / 1ps

package bsp_pkg;

    localparam int NODE_W = 7;
    localparam int OP_W   = 2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [OP_W-1:0]   op_code_t;

    localparam op_code_t OP_ADD    = 2'd0;
    localparam op_code_t OP_SEARCH = 2'd1;
    localparam op_code_t OP_CLEAR  = 2'd2;
    localparam op_code_t OP_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ADD_LINK,
        ST_INIT,
        ST_POP,
        ST_VGET,
        ST_LIST,
        ST_EDGE,
        ST_BFS_END,
        ST_WALK,
        ST_WALK_WAIT,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

// ===== sv/bsp_req_if.sv =====
`timescale 1ns / 1ps

interface bsp_req_if;
    import bsp_pkg::*;

    logic     valid;
    logic     ready;
    op_code_t operation;
    node_t    node_a;
    node_t    node_b;

    modport source (output valid, output operation, output node_a, output node_b, input ready);
    modport sink   (input valid, input operation, input node_a, input node_b, output ready);
endinterface

// ===== sv/bsp_rsp_if.sv =====
`timescale 1ns / 1ps

interface bsp_rsp_if;
    import bsp_pkg::*;

    logic  valid;
    logic  ready;
    logic  found;
    node_t path_length;
    node_t path_node;
    logic  edges_dropped;
    logic  last;

    modport source (output valid, output found, output path_length, output path_node,
                    output edges_dropped, output last, input ready);
    modport sink   (input valid, input found, input path_length, input path_node,
                    input edges_dropped, input last, output ready);
endinterface

// ===== sv/bfs_shortest_path.sv =====
`timescale 1ns / 1ps

// Breadth-first shortest path engine. Edge items (operation 0) build an undirected graph
// kept as linked neighbor lists in on-chip RAM; a search item (operation 1) runs BFS from
// node 1 to node node_count and returns the path one node per result, source first, with
// last on the final node, or a single result with found low if the destination cannot be
// reached. A clear item (operation 2) empties the graph without leaving idle. After an
// edge is accepted, each direction is a read and a write step on the neighbor list RAM,
// plus a link step when that list already had entries. A search seeds the queue, then
// for each popped node reads its list head when the list is non-empty and scans the
// list one entry per step; it then walks the path back from the destination through the
// predecessor RAM and reads it out, holding while the receiver stalls; each dependent
// memory lookup waits on a registered read. Edges past MAX_EDGES are dropped and
// reported in edges_dropped until the next clear. Inputs are taken only while idle.
module bfs_shortest_path #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    bsp_req_if.sink      req,
    bsp_rsp_if.source    rsp,
    input  logic         cfg_we,
    input  bsp_pkg::node_t cfg_wdata
);
    import bsp_pkg::*;

    localparam int NDEPTH = MAX_NODES + 1;
    localparam int NA_W   = $clog2(NDEPTH);
    localparam int SLOTS  = 2 * MAX_EDGES;
    localparam int SW     = $clog2(SLOTS);
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int QA     = $clog2(MAX_NODES);
    localparam int QC     = $clog2(MAX_NODES + 1);

    state_t            state_reg, state_next;
    node_t             cfg_nodes_reg;
    node_t             a_reg, a_next, b_reg, b_next;
    logic              dir_reg, dir_next;
    logic [EC_W-1:0]   stored_reg, stored_next;
    logic              ovf_reg, ovf_next;
    logic [NDEPTH-1:0] head_valid_reg, head_valid_next;
    logic [NDEPTH-1:0] visited_reg, visited_next;
    node_t             v_reg, v_next, u_reg, u_next;
    logic [QC-1:0]     qh_reg, qh_next, qt_reg, qt_next;
    logic [QC-1:0]     len_reg, len_next, k_reg, k_next;

    logic  out_valid_reg, out_valid_next;
    logic  found_reg, found_next, dropped_reg, dropped_next, last_reg, last_next;
    node_t plen_reg, plen_next, pnode_reg, pnode_next;

    // memory ports
    logic            list_we, list_re;
    logic [NA_W-1:0] list_waddr, list_raddr;
    logic [2*SW-1:0] list_wdata, list_rdata;
    logic            tgt_we, tgt_re;
    logic [SW-1:0]   tgt_waddr, tgt_raddr;
    node_t           tgt_wdata, tgt_rdata;
    logic            nxt_we, nxt_re;
    logic [SW-1:0]   nxt_waddr, nxt_raddr;
    logic [SW:0]     nxt_wdata, nxt_rdata;
    logic            pred_we, pred_re;
    logic [NA_W-1:0] pred_waddr, pred_raddr;
    node_t           pred_wdata, pred_rdata;
    logic            q_we, q_re;
    logic [QA-1:0]   q_waddr, q_raddr;
    node_t           q_wdata, q_rdata;
    logic            stk_we, stk_re;
    logic [QA-1:0]   stk_waddr, stk_raddr;
    node_t           stk_wdata, stk_rdata;

    node_t         n_eff, from_node, to_node, w;
    logic [SW-1:0] slot_cur;
    logic          can_load, req_bad;

    bsp_ram #(.WIDTH(2*SW), .DEPTH(NDEPTH)) u_list (
        .clk, .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
        .re(list_re), .raddr(list_raddr), .rdata(list_rdata));
    bsp_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_tgt (
        .clk, .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
        .re(tgt_re), .raddr(tgt_raddr), .rdata(tgt_rdata));
    bsp_ram #(.WIDTH(SW+1), .DEPTH(SLOTS)) u_nxt (
        .clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .re(nxt_re), .raddr(nxt_raddr), .rdata(nxt_rdata));
    bsp_ram #(.WIDTH(NODE_W), .DEPTH(NDEPTH)) u_pred (
        .clk, .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
        .re(pred_re), .raddr(pred_raddr), .rdata(pred_rdata));
    bsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(q_raddr), .rdata(q_rdata));
    bsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack (
        .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata));

    // clamp the node count into range
    always_comb
    begin
        if (cfg_nodes_reg == '0)
            n_eff = NODE_W'(1);
        else if (cfg_nodes_reg > NODE_W'(MAX_NODES))
            n_eff = NODE_W'(MAX_NODES);
        else
            n_eff = cfg_nodes_reg;
    end

    assign from_node = dir_reg ? b_reg : a_reg;
    assign to_node   = dir_reg ? a_reg : b_reg;
    assign slot_cur  = SW'({stored_reg, dir_reg});
    assign w         = tgt_rdata;
    assign can_load  = !out_valid_reg || rsp.ready;
    assign req_bad   = (req.node_a == '0) || (req.node_b == '0) ||
                       (req.node_a > n_eff) || (req.node_b > n_eff);

    // state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_nodes_reg  <= NODE_W'(64);
            stored_reg     <= '0;
            ovf_reg        <= 1'b0;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
                cfg_nodes_reg <= cfg_wdata;
            stored_reg     <= stored_next;
            ovf_reg        <= ovf_next;
            head_valid_reg <= head_valid_next;
            visited_reg    <= visited_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        dir_reg     <= dir_next;
        v_reg       <= v_next;
        u_reg       <= u_next;
        qh_reg      <= qh_next;
        qt_reg      <= qt_next;
        len_reg     <= len_next;
        k_reg       <= k_next;
        found_reg   <= found_next;
        plen_reg    <= plen_next;
        pnode_reg   <= pnode_next;
        dropped_reg <= dropped_next;
        last_reg    <= last_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        dir_next        = dir_reg;
        stored_next     = stored_reg;
        ovf_next        = ovf_reg;
        head_valid_next = head_valid_reg;
        visited_next    = visited_reg;
        v_next          = v_reg;
        u_next          = u_reg;
        qh_next         = qh_reg;
        qt_next         = qt_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        plen_next       = plen_reg;
        pnode_next      = pnode_reg;
        dropped_next    = dropped_reg;
        last_next       = last_reg;
        out_valid_next  = rsp.ready ? 1'b0 : out_valid_reg;
        req.ready       = 1'b0;

        list_we = 1'b0; list_re = 1'b0; list_waddr = '0; list_raddr = '0; list_wdata = '0;
        tgt_we = 1'b0; tgt_re = 1'b0; tgt_waddr = '0; tgt_raddr = '0; tgt_wdata = '0;
        nxt_we = 1'b0; nxt_re = 1'b0; nxt_waddr = '0; nxt_raddr = '0; nxt_wdata = '0;
        pred_we = 1'b0; pred_re = 1'b0; pred_waddr = '0; pred_raddr = '0; pred_wdata = '0;
        q_we = 1'b0; q_re = 1'b0; q_waddr = '0; q_raddr = '0; q_wdata = '0;
        stk_we = 1'b0; stk_re = 1'b0; stk_waddr = '0; stk_raddr = '0; stk_wdata = '0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                a_next    = req.node_a;
                b_next    = req.node_b;
                if (req.valid)
                begin
                    case (req.operation)
                        OP_ADD:
                        begin
                            if (!req_bad)
                            begin
                                if (stored_reg >= EC_W'(MAX_EDGES))
                                    ovf_next = 1'b1;
                                else
                                begin
                                    dir_next   = 1'b0;
                                    state_next = ST_ADD_RD;
                                end
                            end
                        end
                        OP_SEARCH: state_next = ST_INIT;
                        OP_CLEAR:
                        begin
                            head_valid_next = '0;
                            stored_next     = '0;
                            ovf_next        = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            // fetch head and tail of the source list
            ST_ADD_RD:
            begin
                list_re    = 1'b1;
                list_raddr = from_node[NA_W-1:0];
                state_next = ST_ADD_WR;
            end

            // store the new slot and make it the tail
            ST_ADD_WR:
            begin
                tgt_we     = 1'b1;
                tgt_waddr  = slot_cur;
                tgt_wdata  = to_node;
                nxt_we     = 1'b1;
                nxt_waddr  = slot_cur;
                nxt_wdata  = {1'b1, SW'(0)};
                list_we    = 1'b1;
                list_waddr = from_node[NA_W-1:0];
                head_valid_next[from_node[NA_W-1:0]] = 1'b1;
                if (head_valid_reg[from_node[NA_W-1:0]])
                begin
                    list_wdata = {list_rdata[2*SW-1:SW], slot_cur};
                    state_next = ST_ADD_LINK;
                end
                else
                begin
                    list_wdata = {slot_cur, slot_cur};
                    if (!dir_reg)
                    begin
                        dir_next   = 1'b1;
                        state_next = ST_ADD_RD;
                    end
                    else
                    begin
                        stored_next = stored_reg + EC_W'(1);
                        state_next  = ST_IDLE;
                    end
                end
            end

            // chain the old tail to the new slot
            ST_ADD_LINK:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = list_rdata[SW-1:0];
                nxt_wdata = {1'b0, slot_cur};
                if (!dir_reg)
                begin
                    dir_next   = 1'b1;
                    state_next = ST_ADD_RD;
                end
                else
                begin
                    stored_next = stored_reg + EC_W'(1);
                    state_next  = ST_IDLE;
                end
            end

            // seed the queue with the source
            ST_INIT:
            begin
                visited_next    = '0;
                visited_next[1] = 1'b1;
                q_we            = 1'b1;
                q_waddr         = '0;
                q_wdata         = NODE_W'(1);
                qh_next         = '0;
                qt_next         = QC'(1);
                state_next      = ST_POP;
            end

            ST_POP:
            begin
                if (qh_reg == qt_reg)
                    state_next = ST_BFS_END;
                else
                begin
                    q_re       = 1'b1;
                    q_raddr    = qh_reg[QA-1:0];
                    qh_next    = qh_reg + QC'(1);
                    state_next = ST_VGET;
                end
            end

            ST_VGET:
            begin
                v_next = q_rdata;
                if (head_valid_reg[q_rdata[NA_W-1:0]])
                begin
                    list_re    = 1'b1;
                    list_raddr = q_rdata[NA_W-1:0];
                    state_next = ST_LIST;
                end
                else
                    state_next = ST_POP;
            end

            ST_LIST:
            begin
                tgt_re     = 1'b1;
                tgt_raddr  = list_rdata[2*SW-1:SW];
                nxt_re     = 1'b1;
                nxt_raddr  = list_rdata[2*SW-1:SW];
                state_next = ST_EDGE;
            end

            // visit one neighbor, then follow the link
            ST_EDGE:
            begin
                if ((w != '0) && (w <= n_eff) && !visited_reg[w[NA_W-1:0]])
                begin
                    visited_next[w[NA_W-1:0]] = 1'b1;
                    pred_we    = 1'b1;
                    pred_waddr = w[NA_W-1:0];
                    pred_wdata = v_reg;
                    q_we       = 1'b1;
                    q_waddr    = qt_reg[QA-1:0];
                    q_wdata    = w;
                    qt_next    = qt_reg + QC'(1);
                end
                if (nxt_rdata[SW])
                    state_next = ST_POP;
                else
                begin
                    tgt_re    = 1'b1;
                    tgt_raddr = nxt_rdata[SW-1:0];
                    nxt_re    = 1'b1;
                    nxt_raddr = nxt_rdata[SW-1:0];
                end
            end

            ST_BFS_END:
            begin
                if (!visited_reg[n_eff[NA_W-1:0]])
                begin
                    if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = 1'b0;
                        plen_next      = '0;
                        pnode_next     = '0;
                        dropped_next   = ovf_reg;
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    u_next     = n_eff;
                    len_next   = '0;
                    state_next = ST_WALK;
                end
            end

            // push path nodes from destination back to source
            ST_WALK:
            begin
                stk_we    = 1'b1;
                stk_waddr = len_reg[QA-1:0];
                stk_wdata = u_reg;
                len_next  = len_reg + QC'(1);
                if (u_reg == NODE_W'(1))
                begin
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    pred_re    = 1'b1;
                    pred_raddr = u_reg[NA_W-1:0];
                    state_next = ST_WALK_WAIT;
                end
            end

            ST_WALK_WAIT:
            begin
                u_next     = pred_rdata;
                state_next = ST_WALK;
            end

            ST_OUT_RD:
            begin
                stk_re     = 1'b1;
                stk_raddr  = QA'(len_reg - k_reg - QC'(1));
                state_next = ST_OUT_LD;
            end

            // hand one path node to the output register
            ST_OUT_LD:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    plen_next      = NODE_W'(len_reg);
                    pnode_next     = stk_rdata;
                    dropped_next   = ovf_reg;
                    last_next      = ((k_reg + QC'(1)) == len_reg);
                    k_next         = k_reg + QC'(1);
                    state_next     = ((k_reg + QC'(1)) == len_reg) ? ST_IDLE : ST_OUT_RD;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = found_reg;
    assign rsp.path_length   = plen_reg;
    assign rsp.path_node     = pnode_reg;
    assign rsp.edges_dropped = dropped_reg;
    assign rsp.last          = last_reg;
endmodule

// ===== sv/bsp_ram.sv =====
`timescale 1ns / 1ps

module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/bsp_check.sv =====
`timescale 1ns / 1ps

module bsp_check (
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             found,
    input bsp_pkg::node_t   path_length,
    input bsp_pkg::node_t   path_node,
    input logic             last
);
    import bsp_pkg::*;

    // hold a stalled item
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a miss is a single empty item
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> last && path_length == '0 && path_node == '0)
        else $error("bad not-found result");

    // a path of one node is the source alone
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found && path_length == NODE_W'(1) |-> last && path_node == NODE_W'(1))
        else $error("bad single-node path");

    // length stays fixed across one path
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && found && !last |=>
            !rsp_valid || (found && $stable(path_length)))
        else $error("path length changed within a path");
endmodule

bind bfs_shortest_path bsp_check u_bsp_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .found       (rsp.found),
    .path_length (rsp.path_length),
    .path_node   (rsp.path_node),
    .last        (rsp.last)
);

// ===== bench/bfs_shortest_path_tb.sv =====
`timescale 1ns / 1ps

module bfs_shortest_path_tb;
    import bsp_pkg::*;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int NIL = -1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        op_code_t operation;
        node_t    node_a;
        node_t    node_b;
    } edge_item_t;

    typedef struct packed {
        logic  found;
        node_t path_length;
        node_t path_node;
        logic  edges_dropped;
        logic  last;
    } path_step_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    node_t cfg_wdata;

    bsp_req_if req_bus ();
    bsp_rsp_if rsp_bus ();

    bfs_shortest_path #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_bus.sink),
        .rsp      (rsp_bus.source),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // shadow graph
    int adj_head[MAX_NODES+1];
    int adj_tail[MAX_NODES+1];
    int slot_target[SLOTS];
    int slot_next[SLOTS];
    int edge_total;
    bit dropped_flag;
    int node_limit_reg;

    edge_item_t pending_items[$];
    path_step_t expected_steps[$];
    int fail_count = 0;
    int cycle_count = 0;
    bit hold_go;
    bit hold_off;
    int burst_left;
    int gap_left;
    int stall_phase;

    always #4 clk = ~clk;

    function automatic void send_item(edge_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void expect_step(path_step_t step);
        expected_steps.insert(expected_steps.size(), step);
    endfunction

    function automatic int active_nodes();
        if (node_limit_reg < 1) return 1;
        if (node_limit_reg > MAX_NODES) return MAX_NODES;
        return node_limit_reg;
    endfunction

    function automatic void wipe_graph();
        for (int i = 0; i <= MAX_NODES; i++)
        begin
            adj_head[i] = NIL;
            adj_tail[i] = NIL;
        end
        edge_total = 0;
        dropped_flag = 0;
    endfunction

    function automatic void append_slot(int from, int to, int slot);
        slot_target[slot] = to;
        slot_next[slot] = NIL;
        if (adj_head[from] == NIL)
            adj_head[from] = slot;
        else
            slot_next[adj_tail[from]] = slot;
        adj_tail[from] = slot;
    endfunction

    // BFS over the shadow graph; queue the path steps it yields
    function automatic void predict_path();
        int hop_dist[MAX_NODES+1];
        int prev[MAX_NODES+1];
        int fifo[MAX_NODES];
        int trail[MAX_NODES];
        int n, qh, qt, len, u, v, s, w;
        path_step_t step;
        n = active_nodes();
        qh = 0;
        qt = 0;
        len = 0;
        for (int i = 0; i <= MAX_NODES; i++)
        begin
            hop_dist[i] = 0;
            prev[i] = 0;
        end
        hop_dist[1] = 1;
        fifo[qt] = 1;
        qt++;
        while (qh < qt)
        begin
            v = fifo[qh];
            qh++;
            s = adj_head[v];
            while (s != NIL)
            begin
                w = slot_target[s];
                if (w >= 1 && w <= n && hop_dist[w] == 0 && qt < MAX_NODES)
                begin
                    hop_dist[w] = hop_dist[v] + 1;
                    prev[w] = v;
                    fifo[qt] = w;
                    qt++;
                end
                s = slot_next[s];
            end
        end
        if (hop_dist[n] == 0)
        begin
            step = '{found: 1'b0, path_length: '0, path_node: '0,
                     edges_dropped: dropped_flag, last: 1'b1};
            expect_step(step);
            return;
        end
        u = n;
        while (u != 0 && len < MAX_NODES)
        begin
            trail[len] = u;
            len++;
            u = prev[u];
        end
        for (int k = 0; k < len; k++)
        begin
            step.found = 1'b1;
            step.path_length = node_t'(len);
            step.path_node = node_t'(trail[len-1-k]);
            step.edges_dropped = dropped_flag;
            step.last = (k == len - 1);
            expect_step(step);
        end
    endfunction

    function automatic void predict_item(edge_item_t it);
        int a, b, n;
        a = it.node_a;
        b = it.node_b;
        n = active_nodes();
        case (it.operation)
            OP_ADD:
            begin
                if (a == 0 || b == 0 || a > n || b > n)
                    return;
                if (edge_total >= MAX_EDGES)
                begin
                    dropped_flag = 1;
                    return;
                end
                append_slot(a, b, 2 * edge_total);
                append_slot(b, a, 2 * edge_total + 1);
                edge_total++;
            end
            OP_SEARCH: predict_path();
            OP_CLEAR: wipe_graph();
            default: ;
        endcase
    endfunction

    function automatic edge_item_t make_item(op_code_t op, int a, int b);
        edge_item_t it;
        it.operation = op;
        it.node_a = node_t'(a);
        it.node_b = node_t'(b);
        return it;
    endfunction

    // driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.operation <= OP_ADD;
            req_bus.node_a <= '0;
            req_bus.node_b <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                predict_item(edge_item_t'({req_bus.operation, req_bus.node_a,
                                           req_bus.node_b}));
                void'(pending_items.pop_front());
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    req_bus.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    req_bus.valid <= 1'b1;
                    {req_bus.operation, req_bus.node_a, req_bus.node_b} <= pending_items[0];
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_off)
                rsp_bus.ready <= 1'b0;
            else if (stall_phase[8:7] == 2'd0)
                rsp_bus.ready <= 1'b1;
            else
                rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // count out the long hold-off once the stimulus asks for it
    initial
    begin
        hold_off = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitor: compare each result against the oldest expectation
    always @(posedge clk)
    begin
        path_step_t got, want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = '{rsp_bus.found, rsp_bus.path_length, rsp_bus.path_node,
                    rsp_bus.edges_dropped, rsp_bus.last};
            if (expected_steps.size() == 0)
            begin
                $error("unexpected result item %p", got);
                fail_count++;
            end
            else
            begin
                want = expected_steps.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    fail_count++;
                end
                if (got.path_length !== want.path_length)
                begin
                    $error("path_length: expected %0d, got %0d",
                           want.path_length, got.path_length);
                    fail_count++;
                end
                if (got.path_node !== want.path_node)
                begin
                    $error("path_node: expected %0d, got %0d", want.path_node, got.path_node);
                    fail_count++;
                end
                if (got.edges_dropped !== want.edges_dropped)
                begin
                    $error("edges_dropped: expected %0d, got %0d",
                           want.edges_dropped, got.edges_dropped);
                    fail_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || req_bus.valid || expected_steps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= node_t'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        node_limit_reg = value & 8'h7f;
    endtask

    // random chain-like graph: mostly edges along a spine, then a search
    task automatic queue_random_graph(int n, int edges);
        int a, b;
        for (int i = 0; i < edges; i++)
        begin
            case ($urandom_range(0, 9))
                0: begin a = $urandom_range(0, 127); b = $urandom_range(0, 127); end
                1, 2: begin a = $urandom_range(1, n); b = $urandom_range(1, n); end
                default:
                begin
                    a = $urandom_range(1, n);
                    b = (a < n) ? a + $urandom_range(1, 3) : a;
                    if (b > n) b = n;
                end
            endcase
            send_item(make_item(OP_ADD, a, b));
        end
        if ($urandom_range(0, 15) == 0)
            send_item(make_item(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127)));
        send_item(make_item(OP_SEARCH, $urandom_range(0, 127), $urandom_range(0, 127)));
    endtask

    initial
    begin
        int n;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        hold_go = 0;
        node_limit_reg = 64;
        wipe_graph();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset node count 64, empty graph, bad endpoints, self loop
        send_item(make_item(OP_SEARCH, 0, 0));
        send_item(make_item(OP_ADD, 0, 5));
        send_item(make_item(OP_ADD, 65, 1));
        send_item(make_item(OP_ADD, 127, 127));
        send_item(make_item(OP_ADD, 1, 1));
        send_item(make_item(OP_ADD, 1, 64));
        send_item(make_item(OP_ADD, 1, 2));
        send_item(make_item(OP_ADD, 2, 64));
        send_item(make_item(OP_SEARCH, 127, 127));
        send_item(make_item(OP_UNUSED, 1, 64));
        send_item(make_item(OP_CLEAR, 0, 0));
        send_item(make_item(OP_SEARCH, 0, 0));
        wait_idle();

        // single node, then out-of-range register values
        write_node_count(1);
        send_item(make_item(OP_SEARCH, 0, 0));
        send_item(make_item(OP_ADD, 1, 2));
        wait_idle();
        write_node_count(0);
        send_item(make_item(OP_SEARCH, 0, 0));
        wait_idle();
        write_node_count(127);
        send_item(make_item(OP_ADD, 1, 64));
        send_item(make_item(OP_SEARCH, 0, 0));
        wait_idle();

        // lowered node count: neighbors above it are skipped
        write_node_count(3);
        send_item(make_item(OP_SEARCH, 0, 0));
        send_item(make_item(OP_ADD, 1, 3));
        send_item(make_item(OP_SEARCH, 0, 0));
        wait_idle();

        // full-length chain on 64 nodes while the receiver holds off
        write_node_count(64);
        send_item(make_item(OP_CLEAR, 0, 0));
        for (int i = 1; i < 64; i++)
            send_item(make_item(OP_ADD, i, i + 1));
        send_item(make_item(OP_SEARCH, 0, 0));
        send_item(make_item(OP_SEARCH, 0, 0));
        send_item(make_item(OP_ADD, 1, 5));
        hold_go = 1;
        wait_idle();

        // capacity: top up the chain past MAX_EDGES, then search and clear
        for (int i = 0; i < MAX_EDGES - 64 + 3; i++)
            send_item(make_item(OP_ADD, $urandom_range(1, 64), $urandom_range(1, 64)));
        send_item(make_item(OP_SEARCH, 0, 0));
        send_item(make_item(OP_CLEAR, 0, 0));
        send_item(make_item(OP_SEARCH, 0, 0));
        wait_idle();

        // random phases: small graphs, each cleared, different node counts
        for (int phase = 0; phase < 3; phase++)
        begin
            n = $urandom_range(2, 8);
            write_node_count(n);
            send_item(make_item(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127)));
            queue_random_graph(n, $urandom_range(2, n));
            wait_idle();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
sv/bsp_pkg.sv
sv/bsp_req_if.sv
sv/bsp_rsp_if.sv
sv/bsp_ram.sv
sv/bfs_shortest_path.sv
sv/bsp_check.sv
bench/bfs_shortest_path_tb.sv
